>>> rtl/kphid_pkg.sv
// Shared types and constants of the keypad HID report builder.
// No dependencies; used by every module of the block.
package kphid_pkg;

    localparam int NUM_KEYS  = 10;
    localparam int MAX_SLOTS = 6;
    localparam int KEY_W     = $clog2(NUM_KEYS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SAMPLE_W  = 10;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 4;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 88;
    localparam logic [SAMPLE_W-1:0] MASK_RESET = 10'h3FF;

    typedef enum logic {
        MODE_SCAN  = 1'b0,
        MODE_TABLE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        TBL_KEY   = 2'd0,
        TBL_MOD   = 2'd1,
        TBL_MOUSE = 2'd2,
        TBL_MEDIA = 2'd3
    } t_tbl_sel;

    typedef struct packed {
        logic [5:0]          pad;
        logic [CODE_W-1:0]   entry_value;
        logic [IDX_W-1:0]    entry_index;
        logic [1:0]          table_select;
        logic [SAMPLE_W-1:0] second_sample;
        logic [SAMPLE_W-1:0] first_sample;
    } t_in_item;

    typedef struct packed {
        logic [4:0]                pad;
        logic                      keys_changed;
        logic                      mouse_active;
        logic                      keyboard_active;
        logic [IDX_W-1:0]          macro_key;
        logic [IDX_W-1:0]          media_key;
        logic [CODE_W-1:0]         media_usage;
        logic [CODE_W-1:0]         mouse_buttons;
        logic [MAX_SLOTS*8-1:0]    key_slots;
        logic [CODE_W-1:0]         modifier_byte;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
        logic tbl_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic last_key;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> rtl/kphid_ctrl.sv
// Sequencer of the keypad HID report builder: input handshake and scan walk.
// Depends on kphid_pkg; drives the datapath through t_dp_cmd.
module kphid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_mode,
    output logic              o_ready,
    output kphid_pkg::t_dp_cmd o_cmd,
    input  kphid_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == kphid_pkg::MODE_TABLE) begin
                        o_cmd.tbl_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_key) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/kphid_datapath.sv
// Datapath of the keypad HID report builder: code tables, per-key
// accumulators, previous-report state and the result register. Uses kphid_pkg.
module kphid_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kphid_pkg::t_dp_cmd                i_cmd,
    output kphid_pkg::t_dp_sts                o_sts,
    input  kphid_pkg::t_in_item               i_item,
    input  logic                              i_cfg_we,
    input  logic [kphid_pkg::SAMPLE_W-1:0]    i_cfg_mask,
    output kphid_pkg::t_out_item              o_out,
    output logic                              o_out_valid,
    input  logic                              i_out_ready
);

    localparam int KW = kphid_pkg::KEY_W;
    localparam int CW = kphid_pkg::CODE_W;
    localparam int NK = kphid_pkg::NUM_KEYS;
    localparam int MS = kphid_pkg::MAX_SLOTS;
    localparam int SW = kphid_pkg::SAMPLE_W;
    localparam int XW = kphid_pkg::IDX_W;

    logic [CW-1:0] r_key_tbl   [NK];
    logic [CW-1:0] r_mod_tbl   [NK];
    logic [CW-1:0] r_mouse_tbl [NK];
    logic [CW-1:0] r_media_tbl [NK];

    logic [SW-1:0] r_mask;
    logic [SW-1:0] r_pressed,   n_pressed;
    logic [KW-1:0] r_key,       n_key;
    logic [CW-1:0] r_mod,       n_mod;
    logic [CW-1:0] r_mouse,     n_mouse;
    logic [CW-1:0] r_media,     n_media;
    logic [XW-1:0] r_media_key, n_media_key;
    logic [XW-1:0] r_macro_key, n_macro_key;
    logic [kphid_pkg::CNT_W-1:0] r_count, n_count;
    logic [CW-1:0] r_slots [MS];
    logic [CW-1:0] n_slots [MS];
    logic [SW-1:0] r_last_pressed, n_last_pressed;
    logic [CW-1:0] r_prev_mod,     n_prev_mod;
    logic [CW-1:0] r_prev_mouse,   n_prev_mouse;
    logic [MS*8-1:0] r_prev_slots, n_prev_slots;
    kphid_pkg::t_out_item r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [MS*8-1:0] w_slots_flat;
    logic [KW-1:0]   w_wr_idx;
    logic            w_wr_ok;

    assign w_wr_idx = KW'(i_item.entry_index);
    assign w_wr_ok  = ({28'd0, i_item.entry_index} < NK);

    always_comb begin
        for (int k = 0; k < MS; k++) begin
            w_slots_flat[8*k +: 8] = r_slots[k];
        end
    end

    always_comb begin
        n_pressed      = r_pressed;
        n_key          = r_key;
        n_mod          = r_mod;
        n_mouse        = r_mouse;
        n_media        = r_media;
        n_media_key    = r_media_key;
        n_macro_key    = r_macro_key;
        n_count        = r_count;
        n_slots        = r_slots;
        n_last_pressed = r_last_pressed;
        n_prev_mod     = r_prev_mod;
        n_prev_mouse   = r_prev_mouse;
        n_prev_slots   = r_prev_slots;
        n_out          = r_out;
        n_out_valid    = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.start) begin
            n_pressed   = i_item.first_sample & i_item.second_sample;
            n_key       = '0;
            n_mod       = '0;
            n_mouse     = '0;
            n_media     = '0;
            n_media_key = '0;
            n_macro_key = '0;
            n_count     = '0;
            for (int k = 0; k < MS; k++) begin
                n_slots[k] = '0;
            end
        end

        if (i_cmd.step) begin
            n_key = r_key + KW'(1);
            if (r_pressed[r_key]) begin
                n_mod   = r_mod | r_mod_tbl[r_key];
                n_mouse = r_mouse | r_mouse_tbl[r_key];
                if (r_media_tbl[r_key] != '0) begin
                    n_media     = r_media_tbl[r_key];
                    n_media_key = XW'(r_key) + XW'(1);
                end
                if (r_mask[r_key]) begin
                    n_macro_key = XW'(r_key) + XW'(1);
                end
                if (r_count < kphid_pkg::CNT_W'(MS)) begin
                    n_slots[r_count[kphid_pkg::SLOT_W-1:0]] = r_key_tbl[r_key];
                    n_count = r_count + kphid_pkg::CNT_W'(1);
                end
            end
        end

        if (i_cmd.finish) begin
            n_out.pad             = '0;
            n_out.modifier_byte   = r_mod;
            n_out.key_slots       = w_slots_flat;
            n_out.mouse_buttons   = r_mouse;
            n_out.media_usage     = r_media;
            n_out.media_key       = r_media_key;
            n_out.macro_key       = r_macro_key;
            n_out.keyboard_active = (r_mod != '0) || (r_prev_mod != '0) ||
                                    (r_count != '0) || (r_prev_slots != '0);
            n_out.mouse_active    = (r_mouse != '0) || (r_prev_mouse != '0);
            n_out.keys_changed    = (r_pressed != r_last_pressed);
            n_out_valid           = 1'b1;
            n_last_pressed        = r_pressed;
            n_prev_mod            = r_mod;
            n_prev_mouse          = r_mouse;
            n_prev_slots          = w_slots_flat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask         <= kphid_pkg::MASK_RESET;
            r_out_valid    <= 1'b0;
            r_last_pressed <= '0;
            r_prev_mod     <= '0;
            r_prev_mouse   <= '0;
            r_prev_slots   <= '0;
            for (int k = 0; k < NK; k++) begin
                r_key_tbl[k]   <= '0;
                r_mod_tbl[k]   <= '0;
                r_mouse_tbl[k] <= '0;
                r_media_tbl[k] <= '0;
            end
        end else begin
            r_out_valid    <= n_out_valid;
            r_last_pressed <= n_last_pressed;
            r_prev_mod     <= n_prev_mod;
            r_prev_mouse   <= n_prev_mouse;
            r_prev_slots   <= n_prev_slots;
            if (i_cfg_we) begin
                r_mask <= i_cfg_mask;
            end
            if (i_cmd.tbl_wr && w_wr_ok) begin
                case (kphid_pkg::t_tbl_sel'(i_item.table_select))
                    kphid_pkg::TBL_KEY:   r_key_tbl[w_wr_idx]   <= i_item.entry_value;
                    kphid_pkg::TBL_MOD:   r_mod_tbl[w_wr_idx]   <= i_item.entry_value;
                    kphid_pkg::TBL_MOUSE: r_mouse_tbl[w_wr_idx] <= i_item.entry_value;
                    kphid_pkg::TBL_MEDIA: r_media_tbl[w_wr_idx] <= i_item.entry_value;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pressed   <= n_pressed;
        r_key       <= n_key;
        r_mod       <= n_mod;
        r_mouse     <= n_mouse;
        r_media     <= n_media;
        r_media_key <= n_media_key;
        r_macro_key <= n_macro_key;
        r_count     <= n_count;
        r_slots     <= n_slots;
        r_out       <= n_out;
    end

    assign o_sts.last_key = (r_key == KW'(NK - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out          = r_out;
    assign o_out_valid    = r_out_valid;

endmodule

>>> rtl/keypad_hid_report_builder_core.sv
// Keypad HID report builder, top level: stream ports and configuration port.
// Depends on kphid_pkg, kphid_ctrl and kphid_datapath.
//
// A scan transaction (tuser = 0) latches the AND of the two samples on acceptance,
// then walks the per-key tables one key per cycle through all ten keys, and
// then builds the report in the output register. A table transaction
// (tuser = 1) writes its table entry on acceptance and yields no result. The input side
// is ready again as soon as a report is built, while the report waits in the
// output register; building the next report waits until that one is taken.
// The macro enable mask is written through the cfg channel, always ready.
module keypad_hid_report_builder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_sample[9:0], second_sample[19:10], table_select[21:20],
    // entry_index[25:22], entry_value[33:26], zero fill [39:34]
    input  logic [kphid_pkg::IN_W-1:0]     s_axis_tdata,
    // mode[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // modifier_byte[7:0], key_slots[55:8], mouse_buttons[63:56],
    // media_usage[71:64], media_key[75:72], macro_key[79:76],
    // keyboard_active[80], mouse_active[81], keys_changed[82], zero fill [87:83]
    output logic [kphid_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kphid_pkg::SAMPLE_W-1:0] i_cfg_data
);

    kphid_pkg::t_dp_cmd   w_cmd;
    kphid_pkg::t_dp_sts   w_sts;
    kphid_pkg::t_out_item w_out;

    assign o_cfg_ready = 1'b1;

    kphid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    kphid_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (kphid_pkg::t_in_item'(s_axis_tdata)),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_mask  (i_cfg_data),
        .o_out       (w_out),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_out;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for keypad_hid_report_builder_core: scan and table
// transactions are predicted in-bench and every report is checked field by field.
// Depends on kphid_pkg and the keypad_hid_report_builder_core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_ITEMS    = 90;
    localparam int NUM_PHASES     = 6;

    typedef struct {
        kphid_pkg::t_mode    mode;
        kphid_pkg::t_in_item data;
    } t_pend;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [kphid_pkg::IN_W-1:0]     s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [kphid_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [kphid_pkg::SAMPLE_W-1:0] i_cfg_data = '0;

    keypad_hid_report_builder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Predicted block state
    logic [kphid_pkg::CODE_W-1:0]      key_tbl   [kphid_pkg::NUM_KEYS] = '{default: '0};
    logic [kphid_pkg::CODE_W-1:0]      mod_tbl   [kphid_pkg::NUM_KEYS] = '{default: '0};
    logic [kphid_pkg::CODE_W-1:0]      mouse_tbl [kphid_pkg::NUM_KEYS] = '{default: '0};
    logic [kphid_pkg::CODE_W-1:0]      media_tbl [kphid_pkg::NUM_KEYS] = '{default: '0};
    logic [kphid_pkg::SAMPLE_W-1:0]    last_pressed = '0;
    logic [kphid_pkg::CODE_W-1:0]      prev_mod = '0;
    logic [kphid_pkg::CODE_W-1:0]      prev_mouse = '0;
    logic [kphid_pkg::MAX_SLOTS*8-1:0] prev_slots = '0;
    logic [kphid_pkg::SAMPLE_W-1:0]    macro_mask = kphid_pkg::MASK_RESET;

    t_pend                stim_q[$];
    kphid_pkg::t_out_item report_q[$];

    logic in_fire = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   reports_seen = 0;
    int   scans_sent = 0;
    int   table_writes = 0;
    int   cfg_writes = 0;
    int   idle_cycles = 0;
    logic [kphid_pkg::SAMPLE_W-1:0] prev_first = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic kphid_pkg::t_out_item predict_report(input kphid_pkg::t_in_item it);
        kphid_pkg::t_out_item           rep;
        logic [kphid_pkg::SAMPLE_W-1:0] pressed;
        int unsigned                    used;
        rep = '0;
        used = 0;
        pressed = it.first_sample & it.second_sample;
        for (int k = 0; k < kphid_pkg::NUM_KEYS; k++) begin
            if (pressed[k]) begin
                rep.modifier_byte |= mod_tbl[k];
                rep.mouse_buttons |= mouse_tbl[k];
                if (media_tbl[k] != '0) begin
                    rep.media_usage = media_tbl[k];
                    rep.media_key   = kphid_pkg::IDX_W'(k + 1);
                end
                if (macro_mask[k]) begin
                    rep.macro_key = kphid_pkg::IDX_W'(k + 1);
                end
                if (used < kphid_pkg::MAX_SLOTS) begin
                    rep.key_slots[8*used +: 8] = key_tbl[k];
                    used++;
                end
            end
        end
        rep.keyboard_active = (rep.modifier_byte != '0) || (prev_mod != '0) ||
                              (used > 0) || (prev_slots != '0);
        rep.mouse_active = (rep.mouse_buttons != '0) || (prev_mouse != '0);
        rep.keys_changed = (pressed != last_pressed);
        last_pressed = pressed;
        prev_mod     = rep.modifier_byte;
        prev_mouse   = rep.mouse_buttons;
        prev_slots   = rep.key_slots;
        return rep;
    endfunction

    function automatic void load_entry(input kphid_pkg::t_in_item it);
        if (it.entry_index < kphid_pkg::NUM_KEYS) begin
            case (kphid_pkg::t_tbl_sel'(it.table_select))
                kphid_pkg::TBL_KEY:   key_tbl[it.entry_index]   = it.entry_value;
                kphid_pkg::TBL_MOD:   mod_tbl[it.entry_index]   = it.entry_value;
                kphid_pkg::TBL_MOUSE: mouse_tbl[it.entry_index] = it.entry_value;
                default:              media_tbl[it.entry_index] = it.entry_value;
            endcase
        end
    endfunction

    function automatic t_pend scan_item(input logic [kphid_pkg::SAMPLE_W-1:0] first,
                                        input logic [kphid_pkg::SAMPLE_W-1:0] second);
        t_pend p;
        p.mode = kphid_pkg::MODE_SCAN;
        p.data = '0;
        p.data.first_sample  = first;
        p.data.second_sample = second;
        // junk in the table fields must not matter for a scan
        p.data.table_select = 2'($urandom);
        p.data.entry_index  = 4'($urandom);
        p.data.entry_value  = 8'($urandom);
        return p;
    endfunction

    function automatic t_pend table_item(input kphid_pkg::t_tbl_sel sel,
                                         input logic [kphid_pkg::IDX_W-1:0] idx,
                                         input logic [kphid_pkg::CODE_W-1:0] val);
        t_pend p;
        p.mode = kphid_pkg::MODE_TABLE;
        p.data = '0;
        p.data.table_select = sel;
        p.data.entry_index  = idx;
        p.data.entry_value  = val;
        // junk in the sample fields must not matter for a table write
        p.data.first_sample  = kphid_pkg::SAMPLE_W'($urandom);
        p.data.second_sample = kphid_pkg::SAMPLE_W'($urandom);
        return p;
    endfunction

    function automatic logic [kphid_pkg::SAMPLE_W-1:0] sparse_keys();
        logic [kphid_pkg::SAMPLE_W-1:0] m;
        m = '0;
        repeat ($urandom_range(1, 3)) m[$urandom_range(kphid_pkg::NUM_KEYS - 1)] = 1'b1;
        return m;
    endfunction

    function automatic t_pend random_item();
        logic [kphid_pkg::SAMPLE_W-1:0] first;
        logic [kphid_pkg::SAMPLE_W-1:0] second;
        logic [kphid_pkg::CODE_W-1:0]   val;
        logic [kphid_pkg::IDX_W-1:0]    idx;
        if ($urandom_range(99) < 25) begin
            val = ($urandom_range(99) < 25) ? '0 : kphid_pkg::CODE_W'($urandom);
            idx = ($urandom_range(99) < 90)
                ? kphid_pkg::IDX_W'($urandom_range(kphid_pkg::NUM_KEYS - 1))
                : kphid_pkg::IDX_W'($urandom_range(15, kphid_pkg::NUM_KEYS));
            return table_item(kphid_pkg::t_tbl_sel'($urandom_range(3)), idx, val);
        end
        case ($urandom_range(3))
            0: first = sparse_keys();
            1: first = kphid_pkg::SAMPLE_W'($urandom);
            2: first = ~sparse_keys();
            default: first = prev_first;
        endcase
        case ($urandom_range(9))
            0, 1:    second = first ^ sparse_keys();
            2:       second = kphid_pkg::SAMPLE_W'($urandom);
            default: second = first;
        endcase
        prev_first = first;
        return scan_item(first, second);
    endfunction

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("report %0d %s: expected 0x%0h, got 0x%0h",
                         reports_seen, fname, want, got);
            end
        end
    endtask

    task automatic check_report(input kphid_pkg::t_out_item got);
        kphid_pkg::t_out_item want;
        if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("report %0d: unexpected, got 0x%0h", reports_seen, got);
            end
            return;
        end
        want = report_q.pop_front();
        check_field("modifier_byte", want.modifier_byte, got.modifier_byte);
        check_field("key_slots", want.key_slots, got.key_slots);
        check_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
        check_field("media_usage", want.media_usage, got.media_usage);
        check_field("media_key", want.media_key, got.media_key);
        check_field("macro_key", want.macro_key, got.macro_key);
        check_field("keyboard_active", want.keyboard_active, got.keyboard_active);
        check_field("mouse_active", want.mouse_active, got.mouse_active);
        check_field("keys_changed", want.keys_changed, got.keys_changed);
        check_field("zero fill", want.pad, got.pad);
    endtask

    // Driver: present the next transaction, hold it until taken; stall the output at random
    always @(negedge i_clk) begin
        t_pend nxt;
        if (!s_axis_tvalid || in_fire) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = stim_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.mode;
                s_axis_tdata  <= nxt.data;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: track mask writes, predict on acceptance, check each report, watch for a hang
    always @(posedge i_clk) begin
        logic fired;
        fired = 1'b0;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            macro_mask = i_cfg_data;
            cfg_writes++;
            fired = 1'b1;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (kphid_pkg::t_mode'(s_axis_tuser) == kphid_pkg::MODE_TABLE) begin
                load_entry(kphid_pkg::t_in_item'(s_axis_tdata));
                table_writes++;
            end else begin
                report_q.push_back(predict_report(kphid_pkg::t_in_item'(s_axis_tdata)));
                scans_sent++;
            end
            fired = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_report(kphid_pkg::t_out_item'(m_axis_tdata));
            reports_seen++;
            fired = 1'b1;
        end
        idle_cycles = fired ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("keypad_hid_report_builder_core: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (stim_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [kphid_pkg::SAMPLE_W-1:0] mask);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [kphid_pkg::SAMPLE_W-1:0] masks [NUM_PHASES];
        int                             errors;
        masks = '{10'h000, 10'h3FF, 10'h001, 10'h200, kphid_pkg::SAMPLE_W'($urandom),
                  kphid_pkg::SAMPLE_W'($urandom)};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        stim_q.push_back(scan_item(10'h000, 10'h000));
        stim_q.push_back(table_item(kphid_pkg::TBL_KEY, 4'd0, 8'h04));
        stim_q.push_back(table_item(kphid_pkg::TBL_KEY, 4'd9, 8'hFF));
        stim_q.push_back(table_item(kphid_pkg::TBL_KEY, 4'd5, 8'h80));
        stim_q.push_back(table_item(kphid_pkg::TBL_MOD, 4'd0, 8'hFF));
        stim_q.push_back(table_item(kphid_pkg::TBL_MOD, 4'd7, 8'h01));
        stim_q.push_back(table_item(kphid_pkg::TBL_MOUSE, 4'd9, 8'h80));
        stim_q.push_back(table_item(kphid_pkg::TBL_MOUSE, 4'd2, 8'h01));
        stim_q.push_back(table_item(kphid_pkg::TBL_MEDIA, 4'd3, 8'hE9));
        stim_q.push_back(table_item(kphid_pkg::TBL_MEDIA, 4'd8, 8'hCD));
        stim_q.push_back(table_item(kphid_pkg::TBL_KEY, 4'd10, 8'h55));
        stim_q.push_back(table_item(kphid_pkg::TBL_MEDIA, 4'd15, 8'hAA));
        stim_q.push_back(scan_item(10'h3FF, 10'h3FF));
        stim_q.push_back(scan_item(10'h3FF, 10'h000));
        stim_q.push_back(scan_item(10'h000, 10'h000));
        stim_q.push_back(scan_item(10'h200, 10'h200));
        stim_q.push_back(scan_item(10'h2AA, 10'h155));
        stim_q.push_back(scan_item(10'h3FF, 10'h3FE));
        stim_q.push_back(scan_item(10'h001, 10'h001));
        stim_q.push_back(scan_item(10'h002, 10'h002));
        stim_q.push_back(scan_item(10'h000, 10'h000));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_mask(masks[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            repeat (PHASE_ITEMS) stim_q.push_back(random_item());
            drain();
        end

        errors = mismatches + report_q.size();
        $display("covered %0d scans and %0d table writes, %0d reports checked",
                 scans_sent, table_writes, reports_seen);
        $display("macro mask written %0d times across %0d idling phases",
                 cfg_writes, NUM_PHASES);
        if (errors == 0) begin
            $display("keypad_hid_report_builder_core: match");
        end else begin
            $display("keypad_hid_report_builder_core: mismatch");
        end
        $finish;
    end

endmodule
